@@ rtl/nugc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package nugc_pkg;

  localparam int FIELD_W     = 4;
  localparam int CFG_W       = 5;
  localparam int LEVEL_LIMIT = 16;
  localparam logic [CFG_W-1:0] GRID_LEVELS_RST = 5'd16;
  localparam logic [CFG_W-1:0] GRID_LEVELS_MIN = 5'd2;

  localparam logic FUNC_PLACE = 1'b0;
  localparam logic FUNC_CLEAR = 1'b1;

  typedef struct packed {
    logic               func;
    logic [FIELD_W-1:0] target_red;
    logic [FIELD_W-1:0] target_green;
    logic [FIELD_W-1:0] target_blue;
  } req_t;

  typedef struct packed {
    logic [FIELD_W-1:0] chosen_red;
    logic [FIELD_W-1:0] chosen_green;
    logic [FIELD_W-1:0] chosen_blue;
    logic               grid_full;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic clr_step;
    logic tcheck;
    logic shell_begin;
    logic scan_step;
    logic rad_inc;
    logic mark;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic req_clear;
    logic clr_last;
    logic target_used;
    logic shell_stop;
    logic scan_last;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

@@ rtl/nugc_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module nugc_ctrl
  import nugc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [8:0] {
    S_CLEAR  = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_LOOKUP = 9'b000000100,
    S_TCHECK = 9'b000001000,
    S_SHELL  = 9'b000010000,
    S_SCAN   = 9'b000100000,
    S_DRAIN  = 9'b001000000,
    S_MARK   = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  state_t state, state_next;
  logic   reply, reply_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    reply_next = reply;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_next = reply ? S_DONE : S_IDLE;
          reply_next = 1'b0;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.load = 1'b1;
          if (sts.req_clear) begin
            state_next = S_CLEAR;
            reply_next = 1'b1;
          end else begin
            state_next = S_LOOKUP;
          end
        end
      end
      S_LOOKUP: state_next = S_TCHECK;
      S_TCHECK: begin
        cmd.tcheck = 1'b1;
        state_next = sts.target_used ? S_SHELL : S_MARK;
      end
      S_SHELL: begin
        if (sts.shell_stop) begin
          state_next = S_MARK;
        end else begin
          cmd.shell_begin = 1'b1;
          state_next      = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        cmd.rad_inc = 1'b1;
        state_next  = S_SHELL;
      end
      S_MARK: begin
        cmd.mark   = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      reply <= 1'b0;
    end else begin
      state <= state_next;
      reply <= reply_next;
    end
  end

endmodule
`default_nettype wire

@@ rtl/nugc_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
module nugc_dp
  import nugc_pkg::*;
#(
  parameter int MAX_LEVELS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  req_t             req,
  input  logic             rsp_ready,
  output logic             rsp_valid,
  output rsp_t             rsp,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_data,
  input  cmd_t             cmd,
  output sts_t             sts
);

  localparam int LEVEL_CAP = (MAX_LEVELS < LEVEL_LIMIT) ? MAX_LEVELS : LEVEL_LIMIT;
  localparam int CW        = $clog2(LEVEL_CAP);
  localparam int RW        = CW + 1;
  localparam int AW        = 3 * CW;
  localparam int D2W       = 2 * CW + 2;
  localparam int DEPTH     = 1 << AW;

  function automatic logic [CW-1:0] absd(input logic [CW-1:0] a, input logic [CW-1:0] b);
    absd = (a > b) ? a - b : b - a;
  endfunction

  function automatic logic [CW-1:0] maxd(input logic [CW-1:0] a, input logic [CW-1:0] b);
    maxd = (a > b) ? a : b;
  endfunction

  // configuration and effective top level
  logic [CFG_W-1:0] grid_levels;
  logic [CFG_W-1:0] levels_eff;
  logic [CFG_W-1:0] top_w;
  logic [CW-1:0]    top_cur;

  always_ff @(posedge clk) begin
    if (rst) grid_levels <= GRID_LEVELS_RST;
    else if (cfg_we) grid_levels <= cfg_data;
  end

  always_comb begin
    levels_eff = grid_levels;
    if (levels_eff < GRID_LEVELS_MIN) levels_eff = GRID_LEVELS_MIN;
    if (levels_eff > CFG_W'(LEVEL_CAP)) levels_eff = CFG_W'(LEVEL_CAP);
    top_w   = levels_eff - CFG_W'(1);
    top_cur = top_w[CW-1:0];
  end

  function automatic logic [CW-1:0] sat_lvl(input logic [FIELD_W-1:0] x,
                                            input logic [CFG_W-1:0] top);
    logic [CFG_W-1:0] xw;
    xw = CFG_W'(x);
    sat_lvl = (xw > top) ? top[CW-1:0] : xw[CW-1:0];
  endfunction

  // item registers
  logic          func_r, searched, found;
  logic [CW-1:0] top_r, tr, tg, tb, br, bg, bb;
  logic [RW-1:0] rad;
  logic [D2W-1:0] best_d2;

  // scan counters and bounds
  logic [CW-1:0] r, g, b, r0, r1, g0, g1, b0, b1;
  logic          ev_valid;
  logic [CW-1:0] er, eg, eb;

  // memory
  logic          mem [0:DEPTH-1];
  logic          rd_data;
  logic [AW-1:0] rd_addr, wr_addr, clr_cnt;
  logic          wr_en;

  assign rd_addr = cmd.scan_step ? {r, g, b} : {tr, tg, tb};
  assign wr_addr = cmd.clr_step ? clr_cnt : {br, bg, bb};
  assign wr_en   = cmd.clr_step | cmd.mark;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= cmd.mark;
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) clr_cnt <= '0;
    else if (cmd.clr_step) clr_cnt <= clr_cnt + AW'(1);
  end

  // shell bounds
  logic [RW-1:0] lo_r, lo_g, lo_b, hi_r, hi_g, hi_b;
  logic [RW-1:0] top_x;
  logic [D2W-1:0] rad_sq;

  assign top_x  = {1'b0, top_r};
  assign lo_r   = {1'b0, tr} - rad;
  assign lo_g   = {1'b0, tg} - rad;
  assign lo_b   = {1'b0, tb} - rad;
  assign hi_r   = {1'b0, tr} + rad;
  assign hi_g   = {1'b0, tg} + rad;
  assign hi_b   = {1'b0, tb} + rad;
  assign rad_sq = D2W'(rad) * D2W'(rad);

  // scan advance: skip interior of the shell along blue
  logic          interior_rg, b_wrap;
  logic [RW-1:0] b_jump, b_inc, b_nx;

  assign interior_rg = ({1'b0, absd(r, tr)} < rad) && ({1'b0, absd(g, tg)} < rad);
  assign b_jump      = hi_b;
  assign b_inc       = {1'b0, b} + RW'(1);
  assign b_nx        = (interior_rg && ({1'b0, b} < b_jump)) ? b_jump : b_inc;
  assign b_wrap      = b_nx > {1'b0, b1};

  // evaluate the point read last cycle
  logic [CW-1:0]  edr, edg, edb, ech;
  logic [D2W-1:0] d2;
  logic           ev_take;

  assign edr     = absd(er, tr);
  assign edg     = absd(eg, tg);
  assign edb     = absd(eb, tb);
  assign ech     = maxd(maxd(edr, edg), edb);
  assign d2      = D2W'(edr) * D2W'(edr) + D2W'(edg) * D2W'(edg) + D2W'(edb) * D2W'(edb);
  assign ev_take = ev_valid && ({1'b0, ech} == rad) && !rd_data && (!found || d2 < best_d2);

  always_ff @(posedge clk) begin
    if (rst) begin
      found    <= 1'b0;
      ev_valid <= 1'b0;
    end else begin
      ev_valid <= cmd.scan_step;
      if (cmd.load) found <= 1'b0;
      else if (ev_take) found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r   <= req.func;
      searched <= 1'b0;
      top_r    <= top_cur;
      tr       <= sat_lvl(req.target_red, top_w);
      tg       <= sat_lvl(req.target_green, top_w);
      tb       <= sat_lvl(req.target_blue, top_w);
      br       <= (req.func == FUNC_CLEAR) ? '0 : sat_lvl(req.target_red, top_w);
      bg       <= (req.func == FUNC_CLEAR) ? '0 : sat_lvl(req.target_green, top_w);
      bb       <= (req.func == FUNC_CLEAR) ? '0 : sat_lvl(req.target_blue, top_w);
      rad      <= RW'(1);
    end else begin
      if (cmd.tcheck) searched <= rd_data;
      if (cmd.rad_inc) rad <= rad + RW'(1);
      if (ev_take) begin
        best_d2 <= d2;
        br      <= er;
        bg      <= eg;
        bb      <= eb;
      end
    end
    if (cmd.shell_begin) begin
      r0 <= ({1'b0, tr} > rad) ? lo_r[CW-1:0] : '0;
      g0 <= ({1'b0, tg} > rad) ? lo_g[CW-1:0] : '0;
      b0 <= ({1'b0, tb} > rad) ? lo_b[CW-1:0] : '0;
      r1 <= (hi_r > top_x) ? top_r : hi_r[CW-1:0];
      g1 <= (hi_g > top_x) ? top_r : hi_g[CW-1:0];
      b1 <= (hi_b > top_x) ? top_r : hi_b[CW-1:0];
      r  <= ({1'b0, tr} > rad) ? lo_r[CW-1:0] : '0;
      g  <= ({1'b0, tg} > rad) ? lo_g[CW-1:0] : '0;
      b  <= ({1'b0, tb} > rad) ? lo_b[CW-1:0] : '0;
    end else if (cmd.scan_step) begin
      if (!b_wrap) begin
        b <= b_nx[CW-1:0];
      end else begin
        b <= b0;
        if (g == g1) begin
          g <= g0;
          r <= r + CW'(1);
        end else begin
          g <= g + CW'(1);
        end
      end
    end
    if (cmd.scan_step) begin
      er <= r;
      eg <= g;
      eb <= b;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) rsp_valid <= 1'b0;
    else if (cmd.out_load) rsp_valid <= 1'b1;
    else if (rsp_ready) rsp_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp.chosen_red   <= FIELD_W'(br);
      rsp.chosen_green <= FIELD_W'(bg);
      rsp.chosen_blue  <= FIELD_W'(bb);
      rsp.grid_full    <= (func_r == FUNC_PLACE) && searched && !found;
    end
  end

  assign sts.req_clear   = (req.func == FUNC_CLEAR);
  assign sts.clr_last    = (clr_cnt == {AW{1'b1}});
  assign sts.target_used = rd_data;
  assign sts.shell_stop  = (rad > top_x) || (found && rad_sq > best_d2);
  assign sts.scan_last   = b_wrap && (g == g1) && (r == r1);
  assign sts.out_free    = !rsp_valid || rsp_ready;

  a_no_mark_in_clear: assert property (@(posedge clk) disable iff (rst)
    !(cmd.mark && cmd.clr_step))
    else $error("mark issued during clear sweep");

  a_found_nonzero: assert property (@(posedge clk) disable iff (rst)
    found |-> best_d2 != '0)
    else $error("search hit with zero distance");

  a_full_is_target: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load && searched && !found && !func_r |-> br == tr && bg == tg && bb == tb)
    else $error("full result differs from target");

  a_scan_in_box: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_step |-> r >= r0 && r <= r1 && g >= g0 && g <= g1 && b >= b0 && b <= b1)
    else $error("scan point outside shell box");

endmodule
`default_nettype wire

@@ rtl/nearest_unused_grid_color.sv @@
// A place request with a free target is marked and its result registered after the lookup
//   and target check; else shells of growing radius are first scanned point by point.
// One request at a time; the next is taken once the result is registered.
// A clear request sweeps the used map one entry per cycle, 2^(3*clog2(min(MAX_LEVELS,16)))
//   entries (4096 at default); the result is registered after it, once the output is free.
// Reset (synchronous) runs the same sweep with req_ready low; grid_levels resets to 16.
`timescale 1ns / 1ps
`default_nettype none
module nearest_unused_grid_color
  import nugc_pkg::*;
#(
  parameter int MAX_LEVELS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  req_t             req,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output rsp_t             rsp,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  nugc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  nugc_dp #(
    .MAX_LEVELS (MAX_LEVELS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp_ready (rsp_ready),
    .rsp_valid (rsp_valid),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
`default_nettype wire
